[hw/rtl/segx_pkg.sv]
// segx_pkg: shared constants and types of the segment intersection block
// no dependencies; used by every module of the block but segx_divider, by scoped names
`timescale 1ns / 1ps
`default_nettype none
package segx_pkg;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int DET_TOL_BITS  = 48;
   localparam int PAR_TOL_BITS  = 17;

   localparam logic [0:0] REG_DET_TOL = 1'b0;
   localparam logic [0:0] REG_PAR_TOL = 1'b1;

   typedef struct packed {
      logic det_ok;
      logic s_neg;
      logic t_neg;
      logic abx_neg;
      logic aby_neg;
   } flags_type;
endpackage
`default_nettype wire

[hw/rtl/segx_csr.sv]
// segx_csr: tolerance registers behind the apb-style port
// depends on segx_pkg
`timescale 1ns / 1ps
`default_nettype none
module segx_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [segx_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [segx_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [segx_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready,
   output logic      [segx_pkg::DET_TOL_BITS-1:0]   det_tol,
   output logic      [segx_pkg::PAR_TOL_BITS-1:0]   par_tol
);
   logic [segx_pkg::DET_TOL_BITS-1:0] det_tol_ff, det_tol_in;
   logic [segx_pkg::PAR_TOL_BITS-1:0] par_tol_ff, par_tol_in;
   logic                              wr_in;
   logic [0:0]                        sel_in;

   assign wr_in  = psel & penable & pwrite;
   assign sel_in = paddr[3];

   always_comb begin
      det_tol_in = det_tol_ff;
      par_tol_in = par_tol_ff;
      if (wr_in) begin
         unique case (sel_in)
            segx_pkg::REG_DET_TOL: det_tol_in = pwdata[segx_pkg::DET_TOL_BITS-1:0];
            segx_pkg::REG_PAR_TOL: par_tol_in = pwdata[segx_pkg::PAR_TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_tol_ff <= '0;
         par_tol_ff <= '0;
      end else begin
         det_tol_ff <= det_tol_in;
         par_tol_ff <= par_tol_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (sel_in)
         segx_pkg::REG_DET_TOL: prdata[segx_pkg::DET_TOL_BITS-1:0] = det_tol_ff;
         segx_pkg::REG_PAR_TOL: prdata[segx_pkg::PAR_TOL_BITS-1:0] = par_tol_ff;
         default: ;
      endcase
   end

   assign pready  = 1'b1;
   assign det_tol = det_tol_ff;
   assign par_tol = par_tol_ff;
endmodule
`default_nettype wire

[hw/rtl/segx_front.sv]
// segx_front: differences, cross products, determinant and numerators, magnitudes
// five register stages; depends on segx_pkg
`timescale 1ns / 1ps
`default_nettype none
module segx_front #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic signed [COORD_BITS-1:0]           ax,
   input  wire logic signed [COORD_BITS-1:0]           ay,
   input  wire logic signed [COORD_BITS-1:0]           bx,
   input  wire logic signed [COORD_BITS-1:0]           by,
   input  wire logic signed [COORD_BITS-1:0]           cx,
   input  wire logic signed [COORD_BITS-1:0]           cy,
   input  wire logic signed [COORD_BITS-1:0]           dx,
   input  wire logic signed [COORD_BITS-1:0]           dy,
   input  wire logic        [segx_pkg::DET_TOL_BITS-1:0] det_tol,
   output logic                                        out_valid,
   output segx_pkg::flags_type                         out_flags,
   output logic             [2*COORD_BITS:0]           dmag,
   output logic             [2*COORD_BITS:0]           smag,
   output logic             [2*COORD_BITS:0]           tmag,
   output logic signed      [COORD_BITS-1:0]           out_ax,
   output logic signed      [COORD_BITS-1:0]           out_ay,
   output logic             [COORD_BITS-1:0]           abx_mag,
   output logic             [COORD_BITS-1:0]           aby_mag
);
   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW;
   localparam int MW = SW - 1;
   localparam int TW = (MW > segx_pkg::DET_TOL_BITS) ? MW : segx_pkg::DET_TOL_BITS;

   logic [4:0] vld_ff;

   // stage 1
   logic signed [DW-1:0] abx_in, aby_in, cdx_in, cdy_in, acx_in, acy_in;
   logic signed [DW-1:0] abx1_ff, aby1_ff, cdx1_ff, cdy1_ff, acx1_ff, acy1_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff;
   // stage 2
   logic signed [SW-1:0] pd0_ff, pd1_ff, ps0_ff, ps1_ff, pt0_ff, pt1_ff;
   logic signed [DW-1:0] abx2_ff, aby2_ff;
   logic signed [COORD_BITS-1:0] ax2_ff, ay2_ff;
   // stage 3
   logic signed [SW-1:0] det3_ff, ns3_ff, nt3_ff;
   logic signed [DW-1:0] abx3_ff, aby3_ff;
   logic signed [COORD_BITS-1:0] ax3_ff, ay3_ff;
   // stage 4
   logic [SW-1:0] dabs_in, sabs_in, tabs_in;
   logic [DW-1:0] abxabs_in, abyabs_in;
   logic [MW-1:0] dmag4_ff, smag4_ff, tmag4_ff;
   logic [COORD_BITS-1:0] abxm4_ff, abym4_ff;
   logic dneg4_ff, sneg4_ff, tneg4_ff, abxneg4_ff, abyneg4_ff;
   logic signed [COORD_BITS-1:0] ax4_ff, ay4_ff;
   // stage 5
   segx_pkg::flags_type flags_in, flags5_ff;
   logic [MW-1:0] dmag5_ff, smag5_ff, tmag5_ff;
   logic [COORD_BITS-1:0] abxm5_ff, abym5_ff;
   logic signed [COORD_BITS-1:0] ax5_ff, ay5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   assign abx_in = DW'(bx) - DW'(ax);
   assign aby_in = DW'(by) - DW'(ay);
   assign cdx_in = DW'(dx) - DW'(cx);
   assign cdy_in = DW'(dy) - DW'(cy);
   assign acx_in = DW'(cx) - DW'(ax);
   assign acy_in = DW'(cy) - DW'(ay);

   assign dabs_in   = det3_ff[SW-1] ? SW'(-det3_ff) : SW'(det3_ff);
   assign sabs_in   = ns3_ff[SW-1]  ? SW'(-ns3_ff)  : SW'(ns3_ff);
   assign tabs_in   = nt3_ff[SW-1]  ? SW'(-nt3_ff)  : SW'(nt3_ff);
   assign abxabs_in = abx3_ff[DW-1] ? DW'(-abx3_ff) : DW'(abx3_ff);
   assign abyabs_in = aby3_ff[DW-1] ? DW'(-aby3_ff) : DW'(aby3_ff);

   always_comb begin
      flags_in.det_ok  = TW'(dmag4_ff) > TW'(det_tol);
      flags_in.s_neg   = sneg4_ff ^ dneg4_ff;
      flags_in.t_neg   = tneg4_ff ^ dneg4_ff;
      flags_in.abx_neg = abxneg4_ff;
      flags_in.aby_neg = abyneg4_ff;
   end

   always_ff @(posedge clock) begin
      abx1_ff <= abx_in;
      aby1_ff <= aby_in;
      cdx1_ff <= cdx_in;
      cdy1_ff <= cdy_in;
      acx1_ff <= acx_in;
      acy1_ff <= acy_in;
      ax1_ff  <= ax;
      ay1_ff  <= ay;

      pd0_ff  <= SW'(cdx1_ff * aby1_ff);
      pd1_ff  <= SW'(cdy1_ff * abx1_ff);
      ps0_ff  <= SW'(cdx1_ff * acy1_ff);
      ps1_ff  <= SW'(cdy1_ff * acx1_ff);
      pt0_ff  <= SW'(abx1_ff * acy1_ff);
      pt1_ff  <= SW'(aby1_ff * acx1_ff);
      abx2_ff <= abx1_ff;
      aby2_ff <= aby1_ff;
      ax2_ff  <= ax1_ff;
      ay2_ff  <= ay1_ff;

      det3_ff <= pd0_ff - pd1_ff;
      ns3_ff  <= ps0_ff - ps1_ff;
      nt3_ff  <= pt0_ff - pt1_ff;
      abx3_ff <= abx2_ff;
      aby3_ff <= aby2_ff;
      ax3_ff  <= ax2_ff;
      ay3_ff  <= ay2_ff;

      dmag4_ff   <= dabs_in[MW-1:0];
      smag4_ff   <= sabs_in[MW-1:0];
      tmag4_ff   <= tabs_in[MW-1:0];
      abxm4_ff   <= abxabs_in[COORD_BITS-1:0];
      abym4_ff   <= abyabs_in[COORD_BITS-1:0];
      dneg4_ff   <= det3_ff[SW-1];
      sneg4_ff   <= ns3_ff[SW-1];
      tneg4_ff   <= nt3_ff[SW-1];
      abxneg4_ff <= abx3_ff[DW-1];
      abyneg4_ff <= aby3_ff[DW-1];
      ax4_ff     <= ax3_ff;
      ay4_ff     <= ay3_ff;

      flags5_ff <= flags_in;
      dmag5_ff  <= dmag4_ff;
      smag5_ff  <= smag4_ff;
      tmag5_ff  <= tmag4_ff;
      abxm5_ff  <= abxm4_ff;
      abym5_ff  <= abym4_ff;
      ax5_ff    <= ax4_ff;
      ay5_ff    <= ay4_ff;
   end

   assign out_valid = vld_ff[4];
   assign out_flags = flags5_ff;
   assign dmag      = dmag5_ff;
   assign smag      = smag5_ff;
   assign tmag      = tmag5_ff;
   assign out_ax    = ax5_ff;
   assign out_ay    = ay5_ff;
   assign abx_mag   = abxm5_ff;
   assign aby_mag   = abym5_ff;
endmodule
`default_nettype wire

[hw/rtl/segx_divider.sv]
// segx_divider: pipelined restoring divider, floor(n * 2^FRAC / d), one quotient bit per stage
// flags quotients too large for QB bits; no package dependency
`timescale 1ns / 1ps
`default_nettype none
module segx_divider #(
   parameter int MW   = 49,
   parameter int QB   = 19,
   parameter int FRAC = 16
) (
   input  wire logic          clock,
   input  wire logic [MW-1:0] n,
   input  wire logic [MW-1:0] d,
   output logic      [QB-1:0] q,
   output logic               ovf
);
   localparam int SH = QB - FRAC;

   logic [MW-1:0] r_ff   [0:QB-1];
   logic [MW-1:0] n_ff   [0:QB-1];
   logic [MW-1:0] d_ff   [0:QB-1];
   logic [QB-1:0] q_ff   [0:QB];
   logic          ovf_ff [0:QB];
   logic          ovf_in;

   assign ovf_in = {{SH{1'b0}}, n} >= {d, {SH{1'b0}}};

   always_ff @(posedge clock) begin
      r_ff[0]   <= n >> SH;
      n_ff[0]   <= n;
      d_ff[0]   <= d;
      q_ff[0]   <= '0;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int P = QB - 1 - k;
      logic          xbit;
      logic [MW:0]   rr;
      logic [MW+1:0] diff;
      logic          ge;

      if (P >= FRAC) begin : g_num
         assign xbit = n_ff[k][P-FRAC];
      end else begin : g_zero
         assign xbit = 1'b0;
      end

      assign rr   = {r_ff[k], xbit};
      assign diff = {1'b0, rr} - {2'b00, d_ff[k]};
      assign ge   = !diff[MW+1];

      always_ff @(posedge clock) begin
         q_ff[k+1]   <= {q_ff[k][QB-2:0], ge};
         ovf_ff[k+1] <= ovf_ff[k];
      end

      if (k < QB - 1) begin : g_pass
         always_ff @(posedge clock) begin
            r_ff[k+1] <= ge ? diff[MW-1:0] : rr[MW-1:0];
            n_ff[k+1] <= n_ff[k];
            d_ff[k+1] <= d_ff[k];
         end
      end
   end

   assign q   = q_ff[QB];
   assign ovf = ovf_ff[QB];
endmodule
`default_nettype wire

[hw/rtl/segx_back.sv]
// segx_back: hit window test on s and t, interpolation of the point, saturation
// two register stages; depends on segx_pkg
`timescale 1ns / 1ps
`default_nettype none
module segx_back #(
   parameter int COORD_BITS = 24,
   parameter int QB         = 19,
   parameter int FRAC       = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire segx_pkg::flags_type                    flags,
   input  wire logic        [QB-1:0]                   qs,
   input  wire logic                                   ovf_s,
   input  wire logic        [QB-1:0]                   qt,
   input  wire logic                                   ovf_t,
   input  wire logic signed [COORD_BITS-1:0]           ax,
   input  wire logic signed [COORD_BITS-1:0]           ay,
   input  wire logic        [COORD_BITS-1:0]           abx_mag,
   input  wire logic        [COORD_BITS-1:0]           aby_mag,
   input  wire logic        [segx_pkg::PAR_TOL_BITS-1:0] par_tol,
   output logic                                        out_valid,
   output logic                                        out_hit,
   output logic signed      [COORD_BITS-1:0]           out_x,
   output logic signed      [COORD_BITS-1:0]           out_y
);
   localparam int MPW = QB + COORD_BITS;
   localparam int OW  = MPW - FRAC;
   localparam int VW  = OW + 2;
   localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [VW-1:0] VMIN = VW'(-(64'sd1 <<< (COORD_BITS - 1)));

   logic [QB-1:0] tol_in, hi_lim_in;
   logic          s_ok_in, t_ok_in, hit_in;
   logic [MPW-1:0] mx_in, my_in;

   logic           vld1_ff, hit1_ff, xneg1_ff, yneg1_ff;
   logic [MPW-1:0] mx1_ff, my1_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff;

   logic [OW-1:0]         offx_in, offy_in;
   logic signed [VW-1:0]  vx_in, vy_in;
   logic signed [COORD_BITS-1:0] satx_in, saty_in;

   logic vld2_ff, hit2_ff;
   logic signed [COORD_BITS-1:0] x2_ff, y2_ff;

   assign tol_in    = QB'(par_tol);
   assign hi_lim_in = QB'(1 << FRAC) + tol_in;

   // s > -tol and s < 1 + tol, in sign and magnitude
   assign s_ok_in = !ovf_s && (flags.s_neg ? (qs < tol_in)
                                           : ((qs != '0 || tol_in != '0) && qs < hi_lim_in));
   assign t_ok_in = !ovf_t && (flags.t_neg ? (qt < tol_in)
                                           : ((qt != '0 || tol_in != '0) && qt < hi_lim_in));
   assign hit_in  = flags.det_ok && s_ok_in && t_ok_in;

   assign mx_in = MPW'(qs) * MPW'(abx_mag);
   assign my_in = MPW'(qs) * MPW'(aby_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   assign offx_in = OW'(mx1_ff >> FRAC);
   assign offy_in = OW'(my1_ff >> FRAC);
   assign vx_in   = xneg1_ff ? VW'(ax1_ff) - VW'({2'b00, offx_in})
                             : VW'(ax1_ff) + VW'({2'b00, offx_in});
   assign vy_in   = yneg1_ff ? VW'(ay1_ff) - VW'({2'b00, offy_in})
                             : VW'(ay1_ff) + VW'({2'b00, offy_in});

   always_comb begin
      if (vx_in > VMAX) begin
         satx_in = COORD_BITS'(VMAX);
      end else if (vx_in < VMIN) begin
         satx_in = COORD_BITS'(VMIN);
      end else begin
         satx_in = COORD_BITS'(vx_in);
      end
      if (vy_in > VMAX) begin
         saty_in = COORD_BITS'(VMAX);
      end else if (vy_in < VMIN) begin
         saty_in = COORD_BITS'(VMIN);
      end else begin
         saty_in = COORD_BITS'(vy_in);
      end
   end

   always_ff @(posedge clock) begin
      hit1_ff  <= hit_in;
      xneg1_ff <= flags.s_neg ^ flags.abx_neg;
      yneg1_ff <= flags.s_neg ^ flags.aby_neg;
      mx1_ff   <= mx_in;
      my1_ff   <= my_in;
      ax1_ff   <= ax;
      ay1_ff   <= ay;

      hit2_ff <= hit1_ff;
      x2_ff   <= hit1_ff ? satx_in : '0;
      y2_ff   <= hit1_ff ? saty_in : '0;
   end

   assign out_valid = vld2_ff;
   assign out_hit   = hit2_ff;
   assign out_x     = x2_ff;
   assign out_y     = y2_ff;
endmodule
`default_nettype wire

[hw/rtl/segment_intersection.sv]
// segment_intersection: top level, parametric intersection of segments AB and CD
// depends on segx_pkg, segx_csr, segx_front, segx_divider, segx_back
//
//   channel   ports                      direction   transfer
//   request   start/busy, req_*          in          start & !busy
//   response  rsp_valid, rsp_*           out         rsp_valid
//   csr       psel/penable/pwrite/...    in/out      psel & penable & pwrite
//
// one segment pair per cycle; busy is high only during reset.
// QB = max(PARAM_FRAC, 17) + 2 is the quotient width of the divider pipeline,
// which forms one quotient bit per stage.
// synchronous reset clears the valid bits and the tolerance registers.
// the response side never stalls; every transfer yields one result.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection #(
   parameter int COORD_BITS = 24,
   parameter int PARAM_FRAC = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [COORD_BITS-1:0]           req_first_start_x,
   input  wire logic signed [COORD_BITS-1:0]           req_first_start_y,
   input  wire logic signed [COORD_BITS-1:0]           req_first_end_x,
   input  wire logic signed [COORD_BITS-1:0]           req_first_end_y,
   input  wire logic signed [COORD_BITS-1:0]           req_second_start_x,
   input  wire logic signed [COORD_BITS-1:0]           req_second_start_y,
   input  wire logic signed [COORD_BITS-1:0]           req_second_end_x,
   input  wire logic signed [COORD_BITS-1:0]           req_second_end_y,
   output logic                                        rsp_valid,
   output logic                                        rsp_hit,
   output logic signed      [COORD_BITS-1:0]           rsp_cross_x,
   output logic signed      [COORD_BITS-1:0]           rsp_cross_y,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic        [segx_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic        [segx_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic             [segx_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                        pready
);
   localparam int MW = 2 * COORD_BITS + 1;
   localparam int QB = (PARAM_FRAC >= segx_pkg::PAR_TOL_BITS) ? PARAM_FRAC + 2
                                                               : segx_pkg::PAR_TOL_BITS + 2;

   logic [segx_pkg::DET_TOL_BITS-1:0] det_tol;
   logic [segx_pkg::PAR_TOL_BITS-1:0] par_tol;

   logic                         f_valid;
   segx_pkg::flags_type          f_flags;
   logic [MW-1:0]                f_dmag, f_smag, f_tmag;
   logic signed [COORD_BITS-1:0] f_ax, f_ay;
   logic [COORD_BITS-1:0]        f_abx_mag, f_aby_mag;

   logic [QB-1:0] qs, qt;
   logic          ovf_s, ovf_t;

   logic                         vld_ff   [0:QB];
   segx_pkg::flags_type          flags_ff [0:QB];
   logic signed [COORD_BITS-1:0] ax_ff    [0:QB];
   logic signed [COORD_BITS-1:0] ay_ff    [0:QB];
   logic [COORD_BITS-1:0]        abxm_ff  [0:QB];
   logic [COORD_BITS-1:0]        abym_ff  [0:QB];

   assign busy = reset;

   segx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .det_tol (det_tol),
      .par_tol (par_tol)
   );

   segx_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & !busy),
      .ax        (req_first_start_x),
      .ay        (req_first_start_y),
      .bx        (req_first_end_x),
      .by        (req_first_end_y),
      .cx        (req_second_start_x),
      .cy        (req_second_start_y),
      .dx        (req_second_end_x),
      .dy        (req_second_end_y),
      .det_tol   (det_tol),
      .out_valid (f_valid),
      .out_flags (f_flags),
      .dmag      (f_dmag),
      .smag      (f_smag),
      .tmag      (f_tmag),
      .out_ax    (f_ax),
      .out_ay    (f_ay),
      .abx_mag   (f_abx_mag),
      .aby_mag   (f_aby_mag)
   );

   segx_divider #(.MW(MW), .QB(QB), .FRAC(PARAM_FRAC)) u_div_s (
      .clock (clock),
      .n     (f_smag),
      .d     (f_dmag),
      .q     (qs),
      .ovf   (ovf_s)
   );

   segx_divider #(.MW(MW), .QB(QB), .FRAC(PARAM_FRAC)) u_div_t (
      .clock (clock),
      .n     (f_tmag),
      .d     (f_dmag),
      .q     (qt),
      .ovf   (ovf_t)
   );

   // side data delayed alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QB; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= f_valid;
         for (int i = 1; i <= QB; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_ff[0] <= f_flags;
      ax_ff[0]    <= f_ax;
      ay_ff[0]    <= f_ay;
      abxm_ff[0]  <= f_abx_mag;
      abym_ff[0]  <= f_aby_mag;
      for (int i = 1; i <= QB; i++) begin
         flags_ff[i] <= flags_ff[i-1];
         ax_ff[i]    <= ax_ff[i-1];
         ay_ff[i]    <= ay_ff[i-1];
         abxm_ff[i]  <= abxm_ff[i-1];
         abym_ff[i]  <= abym_ff[i-1];
      end
   end

   segx_back #(.COORD_BITS(COORD_BITS), .QB(QB), .FRAC(PARAM_FRAC)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[QB]),
      .flags     (flags_ff[QB]),
      .qs        (qs),
      .ovf_s     (ovf_s),
      .qt        (qt),
      .ovf_t     (ovf_t),
      .ax        (ax_ff[QB]),
      .ay        (ay_ff[QB]),
      .abx_mag   (abxm_ff[QB]),
      .aby_mag   (abym_ff[QB]),
      .par_tol   (par_tol),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_x     (rsp_cross_x),
      .out_y     (rsp_cross_y)
   );
endmodule
`default_nettype wire

[hw/rtl/segx_checker.sv]
// segx_checker: port-level assertions for segment_intersection, bound to the top level
// depends on segment_intersection
`timescale 1ns / 1ps
`default_nettype none
module segx_checker #(
   parameter int COORD_BITS = 24,
   parameter int PARAM_FRAC = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_hit,
   input wire logic signed [COORD_BITS-1:0] rsp_cross_x,
   input wire logic signed [COORD_BITS-1:0] rsp_cross_y
);
   localparam int QB  = (PARAM_FRAC >= 17) ? PARAM_FRAC + 2 : 19;
   localparam int LAT = QB + 8;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transfer without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without transfer");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss with nonzero point");
endmodule

bind segment_intersection segx_checker #(
   .COORD_BITS (COORD_BITS),
   .PARAM_FRAC (PARAM_FRAC)
) u_segx_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_hit     (rsp_hit),
   .rsp_cross_x (rsp_cross_x),
   .rsp_cross_y (rsp_cross_y)
);
`default_nettype wire

[bench/segment_intersection_test.sv]
// segment_intersection_test: self-checking bench for the segment intersection block
// depends on segx_pkg and the segment_intersection top level; predicts hit and point per pair
// drives csr writes, directed and random segment pairs, checks every response in order
`timescale 1ns / 1ps
module segment_intersection_test;
   localparam int CB = 24;
   localparam int PF = 16;
   localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
   localparam longint CMIN = -(64'sd1 <<< (CB - 1));
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [segx_pkg::CSR_ADDR_BITS-1:0] ADDR_DET_TOL =
      segx_pkg::CSR_ADDR_BITS'(8 * segx_pkg::REG_DET_TOL);
   localparam logic [segx_pkg::CSR_ADDR_BITS-1:0] ADDR_PAR_TOL =
      segx_pkg::CSR_ADDR_BITS'(8 * segx_pkg::REG_PAR_TOL);

   typedef struct {
      logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct {
      logic                 hit;
      logic signed [CB-1:0] x, y;
   } crossing_type;

   class crossing_scoreboard;
      crossing_type   expected_q[$];
      longint         det_tol;
      longint         par_tol;
      int             errors;
      int             checked;
      int             hits;

      function new();
         det_tol = 0;
         par_tol = 0;
         errors  = 0;
         checked = 0;
         hits    = 0;
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      function longint param_quot(longint n, longint dmag, bit dneg);
         longint nmag, q0, r, frac, q;
         nmag = n < 0 ? -n : n;
         q0   = nmag / dmag;
         r    = nmag % dmag;
         frac = 0;
         if (q0 >= (64'sd1 <<< 20)) begin
            q = 64'sd1 <<< (20 + PF);
         end else begin
            for (int i = 0; i < PF; i++) begin
               r    = r <<< 1;
               frac = frac <<< 1;
               if (r >= dmag) begin
                  r    = r - dmag;
                  frac = frac | 1;
               end
            end
            q = (q0 <<< PF) | frac;
         end
         return ((n < 0) != dneg) ? -q : q;
      endfunction

      function longint along(longint a, longint s, longint d);
         longint prod, m, v;
         prod = s * d;
         m    = (prod < 0 ? -prod : prod) >>> PF;
         v    = a + (prod < 0 ? -m : m);
         if (v > CMAX) v = CMAX;
         if (v < CMIN) v = CMIN;
         return v;
      endfunction

      function void note(seg_pair_type p);
         longint abx, aby, cdx, cdy, acx, acy, det, dmag, s, t, hi;
         crossing_type e;
         abx  = longint'(p.bx) - longint'(p.ax);
         aby  = longint'(p.by) - longint'(p.ay);
         cdx  = longint'(p.dx) - longint'(p.cx);
         cdy  = longint'(p.dy) - longint'(p.cy);
         acx  = longint'(p.cx) - longint'(p.ax);
         acy  = longint'(p.cy) - longint'(p.ay);
         det  = cdx * aby - cdy * abx;
         dmag = det < 0 ? -det : det;
         e.hit = 1'b0;
         e.x   = '0;
         e.y   = '0;
         if (dmag > det_tol) begin
            hi = (64'sd1 <<< PF) + par_tol;
            s  = param_quot(cdx * acy - cdy * acx, dmag, det < 0);
            t  = param_quot(abx * acy - aby * acx, dmag, det < 0);
            if (s > -par_tol && s < hi && t > -par_tol && t < hi) begin
               e.hit = 1'b1;
               e.x   = CB'(along(longint'(p.ax), s, abx));
               e.y   = CB'(along(longint'(p.ay), s, aby));
            end
         end
         expected_q.push_back(e);
      endfunction

      task check(logic hit, logic signed [CB-1:0] x, logic signed [CB-1:0] y);
         crossing_type e;
         if (expected_q.size() == 0) begin
            report("unexpected response, hit", hit, 0);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (e.hit) hits++;
         if (hit !== e.hit) report("hit", hit, e.hit);
         if (x !== e.x) report("cross_x", x, e.x);
         if (y !== e.y) report("cross_y", y, e.y);
      endtask
   endclass

   logic clock, reset, start, busy;
   logic signed [CB-1:0] req_ax, req_ay, req_bx, req_by, req_cx, req_cy, req_dx, req_dy;
   logic rsp_valid, rsp_hit;
   logic signed [CB-1:0] rsp_cross_x, rsp_cross_y;
   logic psel, penable, pwrite, pready;
   logic [segx_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [segx_pkg::CSR_DATA_BITS-1:0] pwdata, prdata;

   crossing_scoreboard sb;
   bit idle_on;
   int quiet_cycles;
   int sent;

   segment_intersection #(.COORD_BITS(CB), .PARAM_FRAC(PF)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_start_x(req_ax), .req_first_start_y(req_ay),
      .req_first_end_x(req_bx), .req_first_end_y(req_by),
      .req_second_start_x(req_cx), .req_second_start_y(req_cy),
      .req_second_end_x(req_dx), .req_second_end_y(req_dy),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response and request monitors, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check(rsp_hit, rsp_cross_x, rsp_cross_y);
         if (start && !busy) begin
            sb.note('{req_ax, req_ay, req_bx, req_by, req_cx, req_cy, req_dx, req_dy});
            sent++;
         end
         if (rsp_valid || (start && !busy) || (psel && penable)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task csr_write(logic [segx_pkg::CSR_ADDR_BITS-1:0] addr, longint value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_DET_TOL) sb.det_tol = value & ((64'sd1 <<< 48) - 1);
      else sb.par_tol = value & ((64'sd1 <<< 17) - 1);
   endtask

   task drain();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task configure(longint det_tol, longint par_tol);
      drain();
      csr_write(ADDR_DET_TOL, det_tol);
      csr_write(ADDR_PAR_TOL, par_tol);
   endtask

   task send(seg_pair_type p);
      start  <= 1'b1;
      req_ax <= p.ax;
      req_ay <= p.ay;
      req_bx <= p.bx;
      req_by <= p.by;
      req_cx <= p.cx;
      req_cy <= p.cy;
      req_dx <= p.dx;
      req_dy <= p.dy;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function logic signed [CB-1:0] clip(longint v);
      if (v > CMAX) return CB'(CMAX);
      if (v < CMIN) return CB'(CMIN);
      return CB'(v);
   endfunction

   function logic signed [CB-1:0] any_coord();
      case ($urandom_range(0, 9))
         0: return CB'(CMIN);
         1: return CB'(CMAX);
         2: return '0;
         3: return CB'(longint'($urandom_range(0, 64)) - 32);
         default: return CB'($urandom);
      endcase
   endfunction

   // pair whose segments cross near chosen parameters, random scale
   function seg_pair_type crossing_pair();
      seg_pair_type p;
      int sh;
      longint ax, ay, ux, uy, vx, vy, s0, t0, px, py;
      sh = $urandom_range(2, CB - 2);
      ax = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      ay = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      ux = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      uy = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      vx = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      vy = longint'(signed'(CB'($urandom))) >>> (CB - sh);
      s0 = $urandom_range(0, 1100);
      t0 = $urandom_range(0, 1100);
      px = ax + (ux * s0) / 1024;
      py = ay + (uy * s0) / 1024;
      p.ax = clip(ax);
      p.ay = clip(ay);
      p.bx = clip(ax + ux);
      p.by = clip(ay + uy);
      p.cx = clip(px - (vx * t0) / 1024);
      p.cy = clip(py - (vy * t0) / 1024);
      p.dx = clip(px - (vx * t0) / 1024 + vx);
      p.dy = clip(py - (vy * t0) / 1024 + vy);
      return p;
   endfunction

   function seg_pair_type noise_pair();
      return '{any_coord(), any_coord(), any_coord(), any_coord(),
               any_coord(), any_coord(), any_coord(), any_coord()};
   endfunction

   task random_items(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) send(noise_pair());
         else send(crossing_pair());
      end
   endtask

   task directed_items();
      logic signed [CB-1:0] mx, mn;
      mx = CB'(CMAX);
      mn = CB'(CMIN);
      send('{-24'sd100, 24'sd0, 24'sd100, 24'sd0, 24'sd0, -24'sd100, 24'sd0, 24'sd100});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd10, 24'sd0, 24'sd10, 24'sd10, 24'sd0});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd0, 24'sd5, 24'sd10, 24'sd5});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd2, 24'sd0, 24'sd20, 24'sd0});
      send('{24'sd3, 24'sd3, 24'sd3, 24'sd3, 24'sd0, 24'sd0, 24'sd9, 24'sd9});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd10});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd10, -24'sd5, 24'sd10, 24'sd5});
      send('{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd11, -24'sd5, 24'sd11, 24'sd5});
      send('{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, -24'sd1, mx, 24'sd1});
      send('{24'sd0, 24'sd0, 24'sd1, 24'sd1, mx, 24'sd0, mx, 24'sd1});
      send('{mn, mn, mx, mx, mn, mx, mx, mn});
      send('{mx, mn, mn, mx, mn, mn, mx, mx});
      send('{mn, mn, mn, mn, mn, mn, mn, mn});
      send('{mx, mx, mx, mx, mx, mx, mx, mx});
      send('{mn, 24'sd0, mx, 24'sd0, 24'sd0, mn, 24'sd0, mx});
      send('{mx, mx, mn, mn, mx, mn, mn, mx});
      send('{-24'sd1, -24'sd1, -24'sd1, -24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
      send('{24'sd0, 24'sd0, 24'sd7, 24'sd3, 24'sd1, 24'sd5, 24'sd6, -24'sd4});
   endtask

   initial begin
      sb = new();
      reset   = 1'b1;
      start   = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      {req_ax, req_ay, req_bx, req_by, req_cx, req_cy, req_dx, req_dy} = '0;
      idle_on = 1'b1;
      quiet_cycles = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(0, 0);
      directed_items();
      stop_sending();
      configure(0, 65536);
      directed_items();
      random_items(120);
      stop_sending();
      configure(64'h0000_ffff_ffff_ffff, 0);
      directed_items();
      random_items(150);
      stop_sending();
      configure(0, 131071);
      random_items(150);
      stop_sending();
      drain();
      configure(longint'($urandom_range(1, 1 << 20)), $urandom_range(0, 4096));
      random_items(250);
      stop_sending();
      configure(64'h0000_0001_0000_0000, 64'h0001_0000);
      random_items(200);
      stop_sending();
      configure(1, 1);
      random_items(150);
      // sender holds off until every pending pair is answered
      stop_sending();
      drain();
      random_items(150);
      stop_sending();
      configure(longint'($urandom) << 16, $urandom_range(0, 65536));
      random_items(200);
      stop_sending();
      configure(0, 0);
      idle_on = 1'b0;
      random_items(150);
      stop_sending();
      drain();

      $display("sent %0d segment pairs over nine tolerance settings", sent);
      $display("checked %0d responses, %0d with a hit, %0d mismatches",
               sb.checked, sb.hits, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
